// ----- design/assert_macros.svh -----
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/vvt_pkg.sv -----
package vvt_pkg;

   // Default number of table slots.
   localparam int DEF_ENTRIES = 16;

   localparam int KEY_W   = 64;
   localparam int STAMP_W = 64;

   // Command codes.
   typedef enum logic [2:0] {
      CMD_ADD   = 3'd0,
      CMD_GET   = 3'd1,
      CMD_SET   = 3'd2,
      CMD_INC   = 3'd3,
      CMD_MERGE = 3'd4,
      CMD_CLEAR = 3'd5
   } cmd_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // Request beat.
   typedef struct packed {
      logic [2:0]         cmd;
      logic [KEY_W-1:0]   uid;
      logic [STAMP_W-1:0] stamp_in;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [STAMP_W-1:0] stamp_out;
      logic               found;
      logic [1:0]         status;
   } rsp_type;

   // Table lookup result for the current key.
   typedef struct packed {
      logic               hit;
      logic               full;
      logic [STAMP_W-1:0] stamp;
   } lookup_type;

   // Table update request.
   typedef struct packed {
      logic               wr_hit;   // overwrite stamp of the matching slot
      logic               wr_free;  // insert key into the lowest free slot
      logic               clear;    // drop every entry
      logic [STAMP_W-1:0] stamp;
   } update_type;

endpackage

// ----- design/vvt_table.sv -----
module vvt_table #(
   parameter int ENTRIES = vvt_pkg::DEF_ENTRIES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [vvt_pkg::KEY_W-1:0] key,
   input  vvt_pkg::update_type      upd,
   output vvt_pkg::lookup_type      lookup
);
   import vvt_pkg::*;

   logic [ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic [KEY_W-1:0]   entry_uid_ff   [ENTRIES];
   logic [KEY_W-1:0]   entry_uid_in   [ENTRIES];
   logic [STAMP_W-1:0] entry_stamp_ff [ENTRIES];
   logic [STAMP_W-1:0] entry_stamp_in [ENTRIES];
   logic [ENTRIES-1:0] hit_vec;
   logic [ENTRIES-1:0] free_vec;
   logic [STAMP_W-1:0] rd_stamp;

   // Parallel match; uids are unique so at most one slot hits
   always_comb begin
      rd_stamp = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = entry_valid_ff[i] && (entry_uid_ff[i] == key);
         rd_stamp   = rd_stamp | ({STAMP_W{hit_vec[i]}} & entry_stamp_ff[i]);
      end
   end

   // Lowest free slot as a one-hot vector
   assign free_vec = ~entry_valid_ff & (entry_valid_ff + ENTRIES'(1));

   assign lookup.hit   = |hit_vec;
   assign lookup.full  = &entry_valid_ff;
   assign lookup.stamp = rd_stamp;

   // Slot updates
   always_comb begin
      entry_valid_in = entry_valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         entry_uid_in[i]   = entry_uid_ff[i];
         entry_stamp_in[i] = entry_stamp_ff[i];
         if (en) begin
            if (upd.clear) begin
               entry_valid_in[i] = 1'b0;
            end else if (upd.wr_hit && hit_vec[i]) begin
               entry_stamp_in[i] = upd.stamp;
            end else if (upd.wr_free && free_vec[i]) begin
               entry_valid_in[i] = 1'b1;
               entry_uid_in[i]   = key;
               entry_stamp_in[i] = upd.stamp;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      entry_uid_ff   <= entry_uid_in;
      entry_stamp_ff <= entry_stamp_in;
   end

endmodule

// ----- design/vvt_cmd.sv -----
module vvt_cmd (
   input  vvt_pkg::req_type    req,
   input  vvt_pkg::lookup_type lookup,
   output vvt_pkg::update_type upd,
   output vvt_pkg::rsp_type    rsp
);
   import vvt_pkg::*;

   logic [STAMP_W-1:0] inc_stamp;
   logic [STAMP_W-1:0] max_stamp;

   assign inc_stamp = lookup.stamp + STAMP_W'(1);
   assign max_stamp = (req.stamp_in > lookup.stamp) ? req.stamp_in : lookup.stamp;

   // Command decode
   always_comb begin
      upd           = '0;
      rsp.stamp_out = '0;
      rsp.found     = lookup.hit;
      rsp.status    = ST_OK;
      case (req.cmd)
         CMD_ADD, CMD_MERGE: begin
            if (lookup.hit) begin
               if (req.cmd == CMD_ADD) begin
                  rsp.stamp_out = lookup.stamp;
                  rsp.status    = ST_DUP;
               end else begin
                  upd.wr_hit    = 1'b1;
                  upd.stamp     = max_stamp;
                  rsp.stamp_out = max_stamp;
               end
            end else if (lookup.full) begin
               rsp.status = ST_FULL;
            end else begin
               upd.wr_free   = 1'b1;
               upd.stamp     = req.stamp_in;
               rsp.stamp_out = req.stamp_in;
            end
         end
         CMD_SET: begin
            if (lookup.hit) begin
               upd.wr_hit    = 1'b1;
               upd.stamp     = req.stamp_in;
               rsp.stamp_out = req.stamp_in;
            end else begin
               rsp.status = ST_MISSING;
            end
         end
         CMD_INC: begin
            if (lookup.hit) begin
               upd.wr_hit    = 1'b1;
               upd.stamp     = inc_stamp;
               rsp.stamp_out = inc_stamp;
            end else begin
               rsp.status = ST_MISSING;
            end
         end
         CMD_CLEAR: begin
            upd.clear = 1'b1;
         end
         default: begin
            // get, and unused codes
            rsp.stamp_out = lookup.stamp;
         end
      endcase
   end

endmodule

// ----- design/version_vector_table_core.sv -----
// Channel  Dir  Beat type          Handshake
// req_     in   vvt_pkg::req_type  req_valid / req_ready
// rsp_     out  vvt_pkg::rsp_type  rsp_valid / rsp_ready
//
// One command per cycle sustained while responses are not stalled; an accepted
// command is registered in req_ff, then its response in rsp_ff. The rate is set
// by the loop of CAM match, lowest-free-slot pick and slot write on the entry registers.
// Reset clears the valid bits and both pipeline stages; no clearing pass.
// A stalled response holds the command register, which then stalls req_.
module version_vector_table_core #(
   parameter int ENTRIES = vvt_pkg::DEF_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vvt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vvt_pkg::rsp_type rsp_data
);
   import vvt_pkg::*;

   logic       req_valid_ff, req_valid_in;
   req_type    req_ff, req_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       move;
   lookup_type lookup;
   update_type upd;
   rsp_type    rsp_calc;

   // Command register drains whenever the response register can take a beat
   assign move      = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || move;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (req_ready) begin
         req_valid_in = req_valid;
         req_in       = req_data;
      end
   end

   vvt_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .en     (req_valid_ff && move),
      .key    (req_ff.uid),
      .upd    (upd),
      .lookup (lookup)
   );

   vvt_cmd u_cmd (
      .req    (req_ff),
      .lookup (lookup),
      .upd    (upd),
      .rsp    (rsp_calc)
   );

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (move) begin
         rsp_valid_in = req_valid_ff;
         rsp_in       = rsp_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/vvt_checker.sv -----
`include "assert_macros.svh"

module vvt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input vvt_pkg::rsp_type rsp_data
);
   import vvt_pkg::*;

   logic rsp_stall;
   logic out_free;
   logic req_beat;
   logic miss_or_full;
   logic empty_rsp;

   // Handshake shorthands
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign out_free     = !rsp_valid || rsp_ready;
   assign req_beat     = req_valid && req_ready;
   assign miss_or_full = rsp_valid &&
                         (rsp_data.status == ST_MISSING || rsp_data.status == ST_FULL);
   assign empty_rsp    = !rsp_data.found && (rsp_data.stamp_out == '0);

   // Stalled response beat holds
   `ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat not held")

   // Input is never back-pressured while the output side is free
   `ASSERT_IMP(a_req_ready, out_free, req_ready, "req_ready low with free output")

   // Accepted command reaches the output in the cycle after the command stage drains
   `ASSERT_NXT(a_latency, req_beat ##1 out_free, rsp_valid, "response missing after accept")

   // Status codes agree with found and stamp_out
   `ASSERT_IMP(a_status, miss_or_full, empty_rsp, "bad miss or full response")

endmodule

bind version_vector_table_core vvt_checker u_vvt_checker (.*);
